>>> rtl/core/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// shared widths, register indexes and the per-channel history record
// for the two-channel velocity-form pid core
// ----------------------------------------------------------------------------
package ipid_pkg;

    localparam int CHANNELS   = 2;
    localparam int CH_W       = 1;
    localparam int NUM_TAPS   = 3;

    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int COEF_W     = 32;
    localparam int DRIVE_W    = 32;
    localparam int PROD_W     = COEF_W + ERR_W;
    localparam int ACC_W      = PROD_W + 2;

    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int TAP_NOW    = 0;
    localparam int TAP_LAST   = 1;
    localparam int TAP_OLDER  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW_CH0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST_CH0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDER_CH0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_NOW_CH1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST_CH1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDER_CH1 = 3'd5;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // one channel's loop history as kept in the state memory
    typedef struct packed {
        logic [ERR_W-1:0]   err1;
        logic [ERR_W-1:0]   err2;
        logic [DRIVE_W-1:0] drive;
    } ipid_hist_t;

    localparam int HIST_W = $bits(ipid_hist_t);

endpackage

>>> rtl/core/ipid_ram.sv
// ----------------------------------------------------------------------------
// ipid_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module ipid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/incremental_pid_two_channel_core.sv
// ----------------------------------------------------------------------------
// incremental_pid_two_channel_core
// velocity-form discrete pid, two channels, history kept in a small ram
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: one sample per transfer (channel, target, measurement).
//   output stream m_*: one result per sample, in order (drive, clipped flag).
//   cfg_*: six signed q16.16 coefficients, three per channel, written while
//   the core is idle; indexes beyond five are dropped.
// pipeline: an input passes stage 1, stage 2 and the output register.
// throughput: one sample per cycle unless m_tready stalls, any channel
//   order. the per-channel history (two past errors, last drive) lives in
//   a registered-read ram; a back-to-back update of the same channel is
//   served by forwarding from the summing stage and from the last write.
// reset: coefficients and all loop histories read as zero; no clearing pass.
// stall: when m_tready is low the result is held in the output register and
//   earlier stages keep filling until the pipeline is full, then s_tready
//   drops.
// ----------------------------------------------------------------------------
module incremental_pid_two_channel_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] channel, [16:1] target_value, [32:17] measured_value, rest zero
    input  logic [ipid_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] drive, [32] clipped, rest zero
    output logic [ipid_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_we,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import ipid_pkg::*;

    // coefficients
    logic [COEF_W-1:0] coef_reg [CHANNELS][NUM_TAPS];

    // stage 1: error formed, history read in flight
    logic               s1_vld_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    logic [ERR_W-1:0]   s1_err_reg;

    // stage 2: products registered
    logic               s2_vld_reg;
    logic [CH_W-1:0]    s2_ch_reg;
    logic [ERR_W-1:0]   s2_err_reg;
    logic [ERR_W-1:0]   s2_err1_reg;
    logic [DRIVE_W-1:0] s2_drive_reg;
    logic [PROD_W-1:0]  s2_prod_reg [NUM_TAPS];

    // last history write, for the read that missed it
    logic               lw_vld_reg;
    logic [CH_W-1:0]    lw_ch_reg;
    ipid_hist_t         lw_hist_reg;

    logic [CHANNELS-1:0] written_reg;

    // output register
    logic               out_vld_reg;
    logic [DRIVE_W-1:0] out_drive_reg;
    logic               out_clip_reg;

    logic               out_free;
    logic               s2_ready;
    logic               s1_ready;
    logic               in_xfer;
    logic               s2_move;
    logic               s1_move;

    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_target;
    logic [SAMPLE_W-1:0] in_measured;
    logic [ERR_W-1:0]    in_err;

    ipid_hist_t         ram_rdata;
    ipid_hist_t         s1_hist;
    ipid_hist_t         s2_new_hist;
    logic [PROD_W-1:0]  s1_prod [NUM_TAPS];

    logic [ACC_W-1:0]   acc;
    logic               acc_over;
    logic               acc_under;
    logic [DRIVE_W-1:0] sat_drive;
    logic               sat_clip;

    // ---------------- flow control ----------------
    assign out_free = !out_vld_reg || m_tready;
    assign s2_ready = !s2_vld_reg || out_free;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign s_tready = s1_ready;
    assign in_xfer  = s_tvalid && s1_ready;
    assign s2_move  = s2_vld_reg && out_free;
    assign s1_move  = s1_vld_reg && s2_ready;

    // ---------------- input unpack, error ----------------
    assign in_ch       = s_tdata[0];
    assign in_target   = s_tdata[16:1];
    assign in_measured = s_tdata[32:17];
    assign in_err      = {in_target[SAMPLE_W-1], in_target}
                       - {in_measured[SAMPLE_W-1], in_measured};

    // ---------------- history memory ----------------
    ipid_ram #(
        .WIDTH (HIST_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (s2_move),
        .waddr (s2_ch_reg),
        .wdata (s2_new_hist),
        .re    (in_xfer),
        .raddr (in_ch),
        .rdata (ram_rdata)
    );

    // newest history wins: item in stage 2, then the last write, then the ram, else zero if never written
    always_comb
    begin
        if (s2_vld_reg && (s2_ch_reg == s1_ch_reg))
        begin
            s1_hist = s2_new_hist;
        end
        else if (lw_vld_reg && (lw_ch_reg == s1_ch_reg))
        begin
            s1_hist = lw_hist_reg;
        end
        else if (written_reg[s1_ch_reg])
        begin
            s1_hist = ram_rdata;
        end
        else
        begin
            s1_hist = '0;
        end
    end

    assign s1_prod[TAP_NOW]   = $signed(coef_reg[s1_ch_reg][TAP_NOW])
                              * $signed(s1_err_reg);
    assign s1_prod[TAP_LAST]  = $signed(coef_reg[s1_ch_reg][TAP_LAST])
                              * $signed(s1_hist.err1);
    assign s1_prod[TAP_OLDER] = $signed(coef_reg[s1_ch_reg][TAP_OLDER])
                              * $signed(s1_hist.err2);

    // ---------------- sum and saturate ----------------
    assign acc = {{(ACC_W-DRIVE_W){s2_drive_reg[DRIVE_W-1]}}, s2_drive_reg}
               + {{(ACC_W-PROD_W){s2_prod_reg[TAP_NOW][PROD_W-1]}},
                  s2_prod_reg[TAP_NOW]}
               + {{(ACC_W-PROD_W){s2_prod_reg[TAP_LAST][PROD_W-1]}},
                  s2_prod_reg[TAP_LAST]}
               + {{(ACC_W-PROD_W){s2_prod_reg[TAP_OLDER][PROD_W-1]}},
                  s2_prod_reg[TAP_OLDER]};

    assign acc_over  = !acc[ACC_W-1] && (|acc[ACC_W-2:DRIVE_W-1]);
    assign acc_under = acc[ACC_W-1] && !(&acc[ACC_W-2:DRIVE_W-1]);
    assign sat_clip  = acc_over || acc_under;

    always_comb
    begin
        if (acc_over)
        begin
            sat_drive = DRIVE_MAX;
        end
        else if (acc_under)
        begin
            sat_drive = DRIVE_MIN;
        end
        else
        begin
            sat_drive = acc[DRIVE_W-1:0];
        end
    end

    assign s2_new_hist.err1  = s2_err_reg;
    assign s2_new_hist.err2  = s2_err1_reg;
    assign s2_new_hist.drive = sat_drive;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int t = 0; t < NUM_TAPS; t++)
                begin
                    coef_reg[c][t] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_NOW_CH0:   coef_reg[0][TAP_NOW]   <= cfg_data;
                REG_COEF_LAST_CH0:  coef_reg[0][TAP_LAST]  <= cfg_data;
                REG_COEF_OLDER_CH0: coef_reg[0][TAP_OLDER] <= cfg_data;
                REG_COEF_NOW_CH1:   coef_reg[1][TAP_NOW]   <= cfg_data;
                REG_COEF_LAST_CH1:  coef_reg[1][TAP_LAST]  <= cfg_data;
                REG_COEF_OLDER_CH1: coef_reg[1][TAP_OLDER] <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            lw_vld_reg  <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_vld_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_free)
            begin
                out_vld_reg <= s2_vld_reg;
            end
            if (s2_move)
            begin
                lw_vld_reg             <= 1'b1;
                written_reg[s2_ch_reg] <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ch_reg  <= in_ch;
            s1_err_reg <= in_err;
        end
        if (s1_move)
        begin
            s2_ch_reg    <= s1_ch_reg;
            s2_err_reg   <= s1_err_reg;
            s2_err1_reg  <= s1_hist.err1;
            s2_drive_reg <= s1_hist.drive;
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                s2_prod_reg[t] <= s1_prod[t];
            end
        end
        if (s2_move)
        begin
            lw_ch_reg     <= s2_ch_reg;
            lw_hist_reg   <= s2_new_hist;
            out_drive_reg <= sat_drive;
            out_clip_reg  <= sat_clip;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_DATA_W-DRIVE_W-1){1'b0}}, out_clip_reg, out_drive_reg};

    // ---------------- assertions ----------------
    a_clip_is_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[DRIVE_W]) |->
            (m_tdata[DRIVE_W-1:0] == DRIVE_MAX || m_tdata[DRIVE_W-1:0] == DRIVE_MIN))
        else $error("clipped result not at a saturation rail");

    a_last_write_marked: assert property (@(posedge clk) disable iff (!rst_n)
        lw_vld_reg |-> written_reg[lw_ch_reg])
        else $error("forwarded write for a channel never marked written");

    a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_vld_reg && s2_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_vld_reg)
        else $error("accepted sample did not enter stage one");

endmodule

>>> bench/pid_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// watches the sample, result and coefficient ports of the two-channel pid
// core, keeps its own copy of the loop history and coefficients, predicts
// each drive and compares it field by field with the result transfers
// ----------------------------------------------------------------------------
module pid_drive_checker
    import ipid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [0] channel, [16:1] target_value, [32:17] measured_value, rest zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] drive, [32] clipped, rest zero
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    clipped_seen
);

    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               clipped;
    } pid_result_t;

    logic signed [COEF_W-1:0]  coef_q     [CHANNELS][NUM_TAPS];
    logic signed [ERR_W-1:0]   err_last   [CHANNELS];
    logic signed [ERR_W-1:0]   err_older  [CHANNELS];
    logic signed [DRIVE_W-1:0] drive_last [CHANNELS];

    pid_result_t drive_expected_q [$];
    pid_result_t want;
    int          n_fail;
    int          n_results;
    int          n_clipped;

    // velocity-form update of one loop; returns the saturated drive
    function automatic pid_result_t advance_loop(input logic ch,
                                                 input logic signed [SAMPLE_W-1:0] tgt,
                                                 input logic signed [SAMPLE_W-1:0] meas);
        logic signed [ERR_W-1:0] err;
        logic signed [63:0]      sum;
        pid_result_t             res;
        err = tgt - meas;
        sum = drive_last[ch]
            + coef_q[ch][TAP_NOW]   * err
            + coef_q[ch][TAP_LAST]  * err_last[ch]
            + coef_q[ch][TAP_OLDER] * err_older[ch];
        res.clipped = 1'b0;
        if (sum > SUM_HI) begin
            res.drive   = DRIVE_MAX;
            res.clipped = 1'b1;
        end else if (sum < SUM_LO) begin
            res.drive   = DRIVE_MIN;
            res.clipped = 1'b1;
        end else begin
            res.drive = sum[DRIVE_W-1:0];
        end
        drive_last[ch] = res.drive;
        err_older[ch]  = err_last[ch];
        err_last[ch]   = err;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int t = 0; t < NUM_TAPS; t++)
                    coef_q[c][t] = '0;
                err_last[c]   = '0;
                err_older[c]  = '0;
                drive_last[c] = '0;
            end
            drive_expected_q.delete();
            n_fail       = 0;
            n_results    = 0;
            n_clipped    = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
            clipped_seen <= 0;
        end
        else
        begin
            // indexes past the last coefficient are dropped by the core
            if (cfg_we && cfg_index <= REG_COEF_OLDER_CH1)
                coef_q[CH_W'(cfg_index / NUM_TAPS)][2'(cfg_index % NUM_TAPS)] = cfg_data;

            if (s_tvalid && s_tready)
                drive_expected_q.push_back(advance_loop(s_tdata[0], s_tdata[16:1],
                                                        s_tdata[32:17]));

            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (m_tdata[32])
                    n_clipped++;
                if (drive_expected_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: drive %h clipped %b",
                           m_tdata[31:0], m_tdata[32]);
                    n_fail++;
                end
                else
                begin
                    want = drive_expected_q.pop_front();
                    if (m_tdata[31:0] !== want.drive)
                    begin
                        $error("drive: expected %h, actual %h", want.drive, m_tdata[31:0]);
                        n_fail++;
                    end
                    if (m_tdata[32] !== want.clipped)
                    begin
                        $error("clipped: expected %b, actual %b", want.clipped, m_tdata[32]);
                        n_fail++;
                    end
                end
            end

            fail_count   <= n_fail;
            pending      <= drive_expected_q.size();
            results_seen <= n_results;
            clipped_seen <= n_clipped;
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the two-channel velocity-form pid core: directed samples at
// the field extremes, then random samples under six coefficient settings,
// with random idling on both streams and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
    import ipid_pkg::*;

    localparam int                   RANDOM_PER_SETTING = 240;
    localparam int                   NUM_SETTINGS       = 6;
    localparam int                   QUIET_LIMIT        = 5000;
    localparam int                   HOLD_CYCLES        = 400;
    localparam int                   HOLD_AFTER         = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI       = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    int clipped_seen;

    logic [CFG_DATA_W-1:0] coef_set [6];
    int samples_sent;
    int gapless_left;
    int ready_run_left;
    int ready_gap_left;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    always #4 clk = ~clk;

    incremental_pid_two_channel_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .clipped_seen (clipped_seen)
    );

    // sender idle length: mostly none or short, a few long, some gap-free stretches
    function automatic int next_send_gap();
        int r;
        if (gapless_left > 0)
        begin
            gapless_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            gapless_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] tgt,
                               input logic [SAMPLE_W-1:0] meas, input int gap);
        s_tdata  <= {{(S_DATA_W - 2*SAMPLE_W - 1){1'b0}}, meas, tgt, ch};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // waits for every result, then loads coef_set (and the unused indexes if touch_spare)
    task automatic program_coefs(input bit touch_spare);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = int'(REG_COEF_NOW_CH0); i <= int'(REG_COEF_OLDER_CH1); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= coef_set[CFG_IDX_W'(i)];
            @(posedge clk);
        end
        if (touch_spare)
        begin
            for (int i = int'(REG_SPARE_LO); i <= int'(REG_SPARE_HI); i++)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= $urandom;
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // receiver: random ready runs and gaps, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            ready_run_left = 0;
            ready_gap_left = 0;
            hold_left      = 0;
            hold_done      = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (ready_run_left > 0)
        begin
            ready_run_left--;
            m_tready <= 1'b1;
        end
        else if (ready_gap_left > 0)
        begin
            ready_gap_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                ready_run_left = (r < 55) ? $urandom_range(0, 7) : $urandom_range(19, 99);
                m_tready <= 1'b1;
            end
            else
            begin
                if (r < 90)
                    ready_gap_left = $urandom_range(0, 2);
                else if (r < 97)
                    ready_gap_left = $urandom_range(3, 14);
                else
                    ready_gap_left = $urandom_range(19, 59);
                m_tready <= 1'b0;
            end
        end
    end

    // nothing moving on either stream for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic                  ch;
        logic [SAMPLE_W-1:0]   tgt;
        logic [SAMPLE_W-1:0]   meas;
        int                    mode;
        samples_sent = 0;
        gapless_left = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit-ish gains on channel 0, extreme gains on channel 1
        coef_set[REG_COEF_NOW_CH0]   = 32'h0001_0000;
        coef_set[REG_COEF_LAST_CH0]  = 32'hFFFF_8000;
        coef_set[REG_COEF_OLDER_CH0] = 32'h0000_4000;
        coef_set[REG_COEF_NOW_CH1]   = 32'h7FFF_FFFF;
        coef_set[REG_COEF_LAST_CH1]  = 32'h8000_0000;
        coef_set[REG_COEF_OLDER_CH1] = 32'h7FFF_FFFF;
        program_coefs(1'b0);

        send_sample(1'b0, 16'h0000, 16'h0000, 0);
        send_sample(1'b0, 16'h7FFF, 16'h8000, 0);   // largest positive error
        send_sample(1'b0, 16'h8000, 16'h7FFF, 0);   // largest negative error
        send_sample(1'b0, 16'd1000, 16'd1000, 1);
        send_sample(1'b0, 16'hFFFF, 16'h0000, 2);
        send_sample(1'b1, 16'h0000, 16'h0000, 0);
        send_sample(1'b1, 16'h0001, 16'h0000, 0);
        send_sample(1'b1, 16'h0001, 16'h0000, 0);
        send_sample(1'b1, 16'h7FFF, 16'h8000, 0);   // saturates high
        send_sample(1'b1, 16'h8000, 16'h7FFF, 0);   // saturates low
        send_sample(1'b1, 16'h0000, 16'h0000, 1);
        // alternating channels back to back
        send_sample(1'b0, 16'd5, 16'd3, 0);
        send_sample(1'b1, 16'hFFFB, 16'd3, 0);
        send_sample(1'b0, 16'd7, 16'hFFF7, 0);
        send_sample(1'b1, 16'd100, 16'hFF9C, 0);
        send_sample(1'b0, 16'h7FFF, 16'h7FFF, 0);
        send_sample(1'b1, 16'h8000, 16'h8000, 0);
        // same channel back to back, then separated by idle gaps
        send_sample(1'b0, 16'hCFC7, 16'h5BA0, 0);
        send_sample(1'b0, 16'h5BA0, 16'hCFC7, 0);
        send_sample(1'b0, 16'h5555, 16'hAAAA, 1);
        send_sample(1'b0, 16'hAAAA, 16'h5555, 2);
        send_sample(1'b1, 16'h5555, 16'hAAAA, 0);

        for (int setting = 0; setting < NUM_SETTINGS; setting++)
        begin
            for (int i = int'(REG_COEF_NOW_CH0); i <= int'(REG_COEF_OLDER_CH1); i++)
            begin
                logic [CFG_IDX_W-1:0] idx;
                idx = CFG_IDX_W'(i);
                case (setting)
                    0: coef_set[idx] = $urandom;
                    1, 5: coef_set[idx] = $signed($urandom) >>> $urandom_range(14, 26);
                    2:
                        case ($urandom_range(0, 3))
                            0: coef_set[idx] = 32'h7FFF_FFFF;
                            1: coef_set[idx] = 32'h8000_0000;
                            2: coef_set[idx] = 32'hFFFF_FFFF;
                            default: coef_set[idx] = 32'h0000_0001;
                        endcase
                    3: coef_set[idx] = '0;
                    default:
                        coef_set[idx] = $signed($urandom) >>>
                            ((i % NUM_TAPS == TAP_NOW) ? $urandom_range(10, 18)
                                                       : $urandom_range(16, 24));
                endcase
            end
            program_coefs(setting == 3);

            for (int n = 0; n < RANDOM_PER_SETTING; n++)
            begin
                ch   = 1'($urandom_range(0, 1));
                mode = $urandom_range(0, 9);
                tgt  = 16'($urandom);
                if (mode < 6)
                    meas = tgt + 16'($urandom_range(0, 512) - 256);  // tracking loop
                else if (mode < 9)
                    meas = 16'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0: tgt = 16'h7FFF;
                        1: tgt = 16'h8000;
                        2: tgt = 16'h0000;
                        default: tgt = 16'hFFFF;
                    endcase
                    case ($urandom_range(0, 3))
                        0: meas = 16'h7FFF;
                        1: meas = 16'h8000;
                        2: meas = 16'h0000;
                        default: meas = 16'hFFFF;
                    endcase
                end
                send_sample(ch, tgt, meas, next_send_gap());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d samples on two channels under %0d coefficient settings",
                 samples_sent, NUM_SETTINGS + 1);
        $display("run: %0d results compared, %0d saturated, one %0d-cycle output hold-off",
                 results_seen, clipped_seen, HOLD_CYCLES);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
